[sv/slru_pkg.sv]
package slru_pkg;

   // Fixed field widths of the channels and the configuration port.
   localparam int ADDR_W    = 32;
   localparam int MODE_W    = 2;
   localparam int OUTCOME_W = 2;
   localparam int COUNT_W   = 32;
   localparam int STAMP_W   = 32;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   // Wide enough for a way number at the largest supported associativity.
   localparam int WAY_IDX_W = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_STORE  = 2'd1,
      MODE_MODIFY = 2'd2,
      MODE_FETCH  = 2'd3
   } mode_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic {
      S_IDLE,
      S_LOOKUP
   } state_type;

   typedef logic [WAY_IDX_W-1:0] way_type;

   // What a search of one set finds.
   typedef struct packed {
      logic    hit;
      logic    free;
      way_type hit_way;
      way_type free_way;
      way_type victim_way;
   } probe_type;

endpackage

[sv/slru_req_if.sv]
interface slru_req_if import slru_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output mode, output address, input ready);
   modport sink (input valid, input mode, input address, output ready);
endinterface

[sv/slru_rsp_if.sv]
interface slru_rsp_if import slru_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 last;
   logic [COUNT_W-1:0]   hit_total;
   logic [COUNT_W-1:0]   miss_total;
   logic [COUNT_W-1:0]   evict_total;

   modport source (output valid, output outcome, output last, output hit_total,
                   output miss_total, output evict_total, input ready);
   modport sink (input valid, input outcome, input last, input hit_total,
                 input miss_total, input evict_total, output ready);
endinterface

[sv/slru_probe.sv]
module slru_probe import slru_pkg::*; #(
   parameter int WAYS  = 8,
   parameter int TAG_W = 32
) (
   input  logic [WAYS-1:0]              in_use,
   input  logic [WAYS-1:0]              valid,
   input  logic [WAYS-1:0][TAG_W-1:0]   tags,
   input  logic [WAYS-1:0][STAMP_W-1:0] stamps,
   input  logic [TAG_W-1:0]             tag,
   output probe_type                    probe
);

   localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 0;
   localparam int P   = 1 << LVL;

   logic [STAMP_W:0] leaf_key [P];
   logic [STAMP_W:0] node_key [1:2*P-1];
   way_type          node_idx [1:2*P-1];

   // Leaf keys: ways out of use carry a set top bit so they never win.
   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < WAYS) begin : g_real
         assign leaf_key[i] = {!in_use[i], stamps[i]};
      end else begin : g_pad
         assign leaf_key[i] = {(STAMP_W + 1){1'b1}};
      end
   end

   // Minimum tree over the stamps; the left (lower) way wins a tie.
   always_comb begin
      for (int i = 0; i < P; i++) begin
         node_key[P + i] = leaf_key[i];
         node_idx[P + i] = WAY_IDX_W'(i);
      end
      for (int n = P - 1; n >= 1; n--) begin
         if (node_key[2*n + 1] < node_key[2*n]) begin
            node_key[n] = node_key[2*n + 1];
            node_idx[n] = node_idx[2*n + 1];
         end else begin
            node_key[n] = node_key[2*n];
            node_idx[n] = node_idx[2*n];
         end
      end
   end

   // Lowest matching way and lowest free way among the ways in use.
   always_comb begin
      probe = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (in_use[w] && valid[w] && (tags[w] == tag)) begin
            probe.hit     = 1'b1;
            probe.hit_way = WAY_IDX_W'(w);
         end
         if (in_use[w] && !valid[w]) begin
            probe.free     = 1'b1;
            probe.free_way = WAY_IDX_W'(w);
         end
      end
      probe.victim_way = node_idx[1];
   end

endmodule

[sv/set_associative_lru_cache_model.sv]
// Tag-only set-associative cache with LRU replacement.
// An item on req_chan is one access (mode, address). Loads and stores make one
// lookup and one result item on rsp_chan; a modify makes two lookups of the
// same address and two result items, the second with last set; an instruction
// fetch is taken and gives no result item. Each result carries the hit,
// miss or eviction outcome and the running totals after that lookup.
// Each result is registered in the output register. Throughput: one load or
// store per cycle while rsp_chan does not stall; a modify holds req_chan until
// its second lookup. Each lookup does a single read-modify-write of a set row
// on the row memory; a back-to-back access to the same set takes the new row.
// The csr_ port sets the set bits, offset bits and ways in use; write it only
// while no access is in flight.
// Reset clears the totals, the LRU clock and one valid flag per set, so every
// line reads as invalid at once, with no clearing pass.
// When rsp_chan stalls, a finished result waits in the output register; the
// next lookup holds until that register frees, with req_chan.ready low.
module set_associative_lru_cache_model import slru_pkg::*; #(
   parameter int SET_BITS_MAX = 6,
   parameter int WAYS_MAX     = 8,
   parameter int ADDR_BITS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   slru_req_if.sink             req_chan,
   slru_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int NUM_SETS = 1 << SET_BITS_MAX;
   localparam int TAG_W    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int WIDX     = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                             ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef struct packed {
      logic [WAYS_MAX-1:0]              valid;
      logic [WAYS_MAX-1:0][TAG_W-1:0]   tag;
      logic [WAYS_MAX-1:0][STAMP_W-1:0] stamp;
   } row_type;

   // Configuration registers.
   logic [2:0] set_bits_ff;
   logic [4:0] offset_bits_ff;
   logic [3:0] ways_ff;

   // Control state.
   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      two_ff, two_in;
   logic      use_fwd_ff, use_fwd_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Item being looked up.
   logic [SET_BITS_MAX-1:0] set_ff;
   logic [TAG_W-1:0]        tag_ff;

   // Row memory, its read register, per-set valid flags and the forwarded row.
   row_type               row_mem [NUM_SETS];
   row_type               rd_row_ff;
   logic                  rd_ok_ff;
   logic [NUM_SETS-1:0]   row_ok_ff;
   row_type               fwd_row_ff;

   // LRU clock and totals.
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [COUNT_W-1:0] hits_ff, hits_in;
   logic [COUNT_W-1:0] misses_ff, misses_in;
   logic [COUNT_W-1:0] evicts_ff, evicts_in;

   // Result register.
   outcome_type        rsp_outcome_ff;
   logic               rsp_last_ff;
   logic [COUNT_W-1:0] rsp_hits_ff;
   logic [COUNT_W-1:0] rsp_misses_ff;
   logic [COUNT_W-1:0] rsp_evicts_ff;

   logic                    out_free;
   logic                    in_ready;
   logic                    accept;
   logic                    do_lookup;
   logic                    last_lookup;
   logic [ADDR_W-1:0]       addr_m;
   logic [2:0]              s_eff;
   logic [5:0]              shift_all;
   logic [ADDR_W-1:0]       tag_full;
   logic [ADDR_W-1:0]       set_sel;
   logic [SET_BITS_MAX-1:0] set_in;
   logic [TAG_W-1:0]        tag_in;
   logic [3:0]              ways_eff;
   logic [WAYS_MAX-1:0]     in_use;
   row_type                 cur_row;
   row_type                 new_row;
   probe_type               probe;
   outcome_type             outcome;
   logic [WIDX-1:0]         hw;
   logic [WIDX-1:0]         fw;
   logic [WIDX-1:0]         vw;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= 3'd1;
         offset_bits_ff <= 5'd4;
         ways_ff        <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff    <= csr_wdata[2:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata;
            CSR_WAYS:        ways_ff        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Split the incoming address into set and tag.
   always_comb begin
      addr_m    = req_chan.address & ADDR_MASK;
      s_eff     = (int'(set_bits_ff) > SET_BITS_MAX) ? 3'(SET_BITS_MAX) : set_bits_ff;
      shift_all = {1'b0, offset_bits_ff} + {3'b000, s_eff};
      tag_full  = addr_m >> shift_all;
      tag_in    = tag_full[TAG_W-1:0];
      set_sel   = (addr_m >> offset_bits_ff) & ~({ADDR_W{1'b1}} << s_eff);
      set_in    = set_sel[SET_BITS_MAX-1:0];
   end

   // Ways searched and replaced under the current associativity.
   always_comb begin
      if (ways_ff == 4'd0) begin
         ways_eff = 4'd1;
      end else if (int'(ways_ff) > WAYS_MAX) begin
         ways_eff = 4'(WAYS_MAX);
      end else begin
         ways_eff = ways_ff;
      end
      for (int w = 0; w < WAYS_MAX; w++) begin
         in_use[w] = int'(ways_eff) > w;
      end
   end

   // Sequencer: next state, input ready and lookup strobes.
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_chan.ready;
      do_lookup   = 1'b0;
      last_lookup = 1'b0;
      in_ready    = 1'b0;
      state_in    = state_ff;
      pass_in     = pass_ff;
      two_in      = two_ff;
      use_fwd_in  = use_fwd_ff;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
         end
         S_LOOKUP: begin
            if (out_free) begin
               do_lookup   = 1'b1;
               last_lookup = !two_ff || pass_ff;
               in_ready    = last_lookup;
               if (last_lookup) begin
                  state_in = S_IDLE;
               end else begin
                  // The second lookup of a modify sees the row just written.
                  pass_in    = 1'b1;
                  use_fwd_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      accept = req_chan.valid && in_ready;
      if (accept && (mode_type'(req_chan.mode) != MODE_FETCH)) begin
         state_in   = S_LOOKUP;
         pass_in    = 1'b0;
         two_in     = mode_type'(req_chan.mode) == MODE_MODIFY;
         use_fwd_in = do_lookup && (set_in == set_ff);
      end
   end

   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pass_ff    <= 1'b0;
         two_ff     <= 1'b0;
         use_fwd_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         two_ff     <= two_in;
         use_fwd_ff <= use_fwd_in;
      end
   end

   // Capture the item's set and tag.
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
   end

   // Row memory: read on accept, write back at the end of each lookup.
   always_ff @(posedge clock) begin
      if (do_lookup) begin
         row_mem[set_ff] <= new_row;
      end
      if (accept) begin
         rd_row_ff <= row_mem[set_in];
         rd_ok_ff  <= row_ok_ff[set_in];
      end
      if (do_lookup) begin
         fwd_row_ff <= new_row;
      end
   end

   // A set never written since reset reads as all lines invalid.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
      end else if (do_lookup) begin
         row_ok_ff[set_ff] <= 1'b1;
      end
   end

   // Row seen by this lookup.
   always_comb begin
      if (use_fwd_ff) begin
         cur_row = fwd_row_ff;
      end else begin
         cur_row = rd_row_ff;
         if (!rd_ok_ff) begin
            cur_row.valid = '0;
         end
      end
   end

   slru_probe #(
      .WAYS  (WAYS_MAX),
      .TAG_W (TAG_W)
   ) u_probe (
      .in_use (in_use),
      .valid  (cur_row.valid),
      .tags   (cur_row.tag),
      .stamps (cur_row.stamp),
      .tag    (tag_ff),
      .probe  (probe)
   );

   // Update the row and the totals from what the search found.
   always_comb begin
      hw        = probe.hit_way[WIDX-1:0];
      fw        = probe.free_way[WIDX-1:0];
      vw        = probe.victim_way[WIDX-1:0];
      clock_in  = clock_ff + 1'b1;
      new_row   = cur_row;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      evicts_in = evicts_ff;
      if (probe.hit) begin
         new_row.stamp[hw] = clock_in;
         hits_in           = hits_ff + 1'b1;
         outcome           = OUT_HIT;
      end else if (probe.free) begin
         new_row.valid[fw] = 1'b1;
         new_row.tag[fw]   = tag_ff;
         new_row.stamp[fw] = clock_in;
         misses_in         = misses_ff + 1'b1;
         outcome           = OUT_FILL;
      end else begin
         new_row.tag[vw]   = tag_ff;
         new_row.stamp[vw] = clock_in;
         misses_in         = misses_ff + 1'b1;
         evicts_in         = evicts_ff + 1'b1;
         outcome           = OUT_EVICT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (do_lookup) begin
         clock_ff  <= clock_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = do_lookup || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_lookup) begin
         rsp_outcome_ff <= outcome;
         rsp_last_ff    <= last_lookup;
         rsp_hits_ff    <= hits_in;
         rsp_misses_ff  <= misses_in;
         rsp_evicts_ff  <= evicts_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.outcome     = rsp_outcome_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.hit_total   = rsp_hits_ff;
   assign rsp_chan.miss_total  = rsp_misses_ff;
   assign rsp_chan.evict_total = rsp_evicts_ff;

   // Every lookup is either a hit or a miss, and each one advances the clock.
   a_totals_match_clock: assert property (@(posedge clock) disable iff (reset)
      (hits_ff + misses_ff) == clock_ff)
      else $error("hit and miss totals disagree with the LRU clock");

   // No new item is taken between the two lookups of a modify.
   a_no_accept_mid_modify: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP && two_ff && !pass_ff) |-> !in_ready)
      else $error("item taken between the lookups of a modify");

   // A lookup waits, without touching state, while the result register is full.
   a_stall_holds_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP && rsp_valid_ff && !rsp_chan.ready)
      |=> (state_ff == S_LOOKUP && $stable(clock_ff)))
      else $error("lookup proceeded while the result register was full");

endmodule
